### sv/rgaa_pkg.sv
// Package for the radar gate averaging block: sizes, beat and job types, back-end states.
// No dependencies; every other file imports it.
`default_nettype none
package rgaa_pkg;

	localparam int GATES    = 500;
	localparam int SPG_W    = $clog2(65535 / GATES + 1);
	localparam int ACC_W    = 16 + SPG_W;
	localparam int CG_W     = $clog2(GATES + 1);
	localparam int IDX_W    = $clog2(2 * GATES);
	localparam int RECIP_SH = 28;
	localparam logic [28:0] RECIP = 29'((2 ** 28 + GATES - 1) / GATES);
	localparam int PCNT_W   = 13;
	localparam int PULSE_W  = 12;
	localparam int SUM_W    = 44;
	localparam int MEM_W    = SUM_W + 16;
	localparam int CNT_W    = 6;
	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W   = $clog2(FIFO_DEPTH);
	localparam logic [PCNT_W-1:0] PC_RESET = 13'd800;

	typedef struct packed {
		logic signed [15:0] sample_i;
		logic signed [15:0] sample_q;
		logic [15:0]        valid_samples;
	} in_item_t;

	typedef struct packed {
		logic               channel;
		logic [9:0]         gate_index;
		logic [11:0]        pulse_number;
		logic signed [15:0] mean_i;
		logic signed [15:0] mean_q;
		logic [31:0]        rt_value;
		logic               rt_valid;
	} out_item_t;

	// One finished gate handed from the front to the back
	typedef struct packed {
		logic signed [ACC_W-1:0] sum_i;
		logic signed [ACC_W-1:0] sum_q;
		logic [SPG_W-1:0]        spg;
		logic                    channel;
		logic [CG_W-1:0]         gate;
		logic [IDX_W-1:0]        idx;
		logic [PULSE_W-1:0]      pulse;
		logic                    last;
		logic                    accum;
		logic                    fresh;
	} job_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_DIV, BK_SQI, BK_SQQ, BK_ROOT, BK_MUL, BK_ADD, BK_RT, BK_EMIT
	} back_state_t;

endpackage
`default_nettype wire

### sv/rgaa_front.sv
// Front end: takes sample beats, tracks pulse/channel/gate position, sums each gate.
// Depends on rgaa_pkg; pushes one job per finished gate.
`default_nettype none
module rgaa_front import rgaa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire in_item_t          in_data,
	input  wire logic [PCNT_W-1:0] flen,
	input  wire logic              fifo_full,
	output logic                   push,
	output job_t                   job
);

	logic                    in_pulse_q, channel_q, fresh_q;
	logic [15:0]             len_q, sic_q;
	logic [SPG_W-1:0]        spg_q, sig_q;
	logic [CG_W-1:0]         gate_q;
	logic [PULSE_W-1:0]      pulse_q;
	logic signed [ACC_W-1:0] sum_i_q, sum_q_q;

	logic [44:0]             vs_prod;
	logic                    accept, ignore, gate_open, gate_end, chan_end, last;
	logic [SPG_W-1:0]        eff_spg, eff_sig, sig_nx;
	logic [15:0]             eff_len, eff_sic, sic_nx;
	logic [CG_W-1:0]         eff_gate;
	logic                    eff_ch;
	logic signed [ACC_W-1:0] eff_si, eff_sq, acc_i, acc_q;

	assign in_stall = fifo_full;
	assign accept   = in_valid & ~fifo_full;
	assign ignore   = ~in_pulse_q && (in_data.valid_samples == 16'd0);

	// samples per gate: multiply by reciprocal of GATES
	assign vs_prod = 45'(in_data.valid_samples) * 45'(RECIP);

	// position as seen by this beat (a new pulse starts from zero)
	always_comb begin
		if (in_pulse_q) begin
			eff_spg  = spg_q;
			eff_len  = len_q;
			eff_sic  = sic_q;
			eff_sig  = sig_q;
			eff_gate = gate_q;
			eff_ch   = channel_q;
			eff_si   = sum_i_q;
			eff_sq   = sum_q_q;
		end else begin
			eff_spg  = SPG_W'(vs_prod >> RECIP_SH);
			eff_len  = in_data.valid_samples;
			eff_sic  = '0;
			eff_sig  = '0;
			eff_gate = '0;
			eff_ch   = 1'b0;
			eff_si   = '0;
			eff_sq   = '0;
		end
	end

	assign gate_open = (eff_spg != '0) && (eff_gate < CG_W'(GATES));
	assign acc_i     = eff_si + ACC_W'(in_data.sample_i);
	assign acc_q     = eff_sq + ACC_W'(in_data.sample_q);
	assign sig_nx    = eff_sig + SPG_W'(1);
	assign gate_end  = gate_open && (sig_nx >= eff_spg);
	assign sic_nx    = eff_sic + 16'd1;
	assign chan_end  = sic_nx >= eff_len;
	assign last      = ({1'b0, pulse_q} + 13'd1) >= flen;
	assign push      = accept && !ignore && gate_end;

	// job for the back end
	always_comb begin
		job.sum_i   = acc_i;
		job.sum_q   = acc_q;
		job.spg     = eff_spg;
		job.channel = eff_ch;
		job.gate    = eff_gate;
		job.idx     = eff_ch ? IDX_W'(eff_gate) + IDX_W'(GATES) : IDX_W'(eff_gate);
		job.pulse   = pulse_q;
		job.last    = last;
		job.accum   = pulse_q != '0;
		job.fresh   = fresh_q;
	end

	// position and sum registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q <= 1'b0;
			channel_q  <= 1'b0;
			fresh_q    <= 1'b1;
			len_q      <= '0;
			sic_q      <= '0;
			spg_q      <= '0;
			sig_q      <= '0;
			gate_q     <= '0;
			pulse_q    <= '0;
			sum_i_q    <= '0;
			sum_q_q    <= '0;
		end else if (accept && !ignore) begin
			len_q <= eff_len;
			spg_q <= eff_spg;
			if (chan_end || gate_end) begin
				sum_i_q <= '0;
				sum_q_q <= '0;
				sig_q   <= '0;
			end else if (gate_open) begin
				sum_i_q <= acc_i;
				sum_q_q <= acc_q;
				sig_q   <= sig_nx;
			end else begin
				sum_i_q <= eff_si;
				sum_q_q <= eff_sq;
				sig_q   <= eff_sig;
			end
			if (chan_end)
				gate_q <= '0;
			else if (gate_end)
				gate_q <= eff_gate + CG_W'(1);
			else
				gate_q <= eff_gate;
			sic_q      <= chan_end ? '0 : sic_nx;
			channel_q  <= chan_end ? ~eff_ch : eff_ch;
			in_pulse_q <= !(chan_end && eff_ch);
			// end of pulse: advance or close the frame
			if (chan_end && eff_ch) begin
				if (last) begin
					pulse_q <= '0;
					fresh_q <= 1'b1;
				end else begin
					pulse_q <= pulse_q + PULSE_W'(1);
					if (pulse_q != '0 && eff_spg != '0)
						fresh_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

### sv/rgaa_job_fifo.sv
// Short job queue between front and back end.
// Depends on rgaa_pkg for job_t and depth.
`default_nettype none
module rgaa_job_fifo import rgaa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_job,
	input  wire logic pop,
	output job_t      rd_job,
	output logic      full,
	output logic      empty
);

	job_t              slot_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_q, rd_q;
	logic [FPTR_W:0]   cnt_q;

	assign full   = cnt_q == (FPTR_W+1)'(FIFO_DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_job = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= wr_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + FPTR_W'(1);
			if (pop)
				rd_q <= rd_q + FPTR_W'(1);
			cnt_q <= cnt_q + (FPTR_W+1)'(push) - (FPTR_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

### sv/rgaa_back.sv
// Back end: per gate mean divide, square, root, lag-one MAC, frame divide, result register.
// Depends on rgaa_pkg; holds the magnitude/sum memory.
`default_nettype none
module rgaa_back import rgaa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fifo_empty,
	input  wire job_t              job_in,
	output logic                   pop,
	input  wire logic [PCNT_W-1:0] flen,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_item_t              out_data
);

	back_state_t state_q, state_nx;

	logic [MEM_W-1:0]   mem [2*GATES];
	logic [MEM_W-1:0]   rd_q;
	job_t               job_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   a_i_q, a_q_q;
	logic [SPG_W:0]     r_i_q, r_q_q;
	logic               neg_i_q, neg_q_q;
	logic signed [15:0] mi_q, mq_q;
	logic [31:0]        pw_q, rx_q, prod_q;
	logic [19:0]        rrem_q;
	logic [15:0]        root_q;
	logic [SUM_W-1:0]   rtd_q;
	logic [PCNT_W:0]    rtr_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               mem_we, out_load;
	logic [SPG_W:0]     rs_i, rs_q;
	logic               ge_i, ge_q;
	logic signed [15:0] mi_w, mq_w;
	logic [19:0]        rrem_sh, trial;
	logic               ge_r;
	logic [PCNT_W:0]    rt_sh;
	logic               ge_t;
	logic [SUM_W-1:0]   new_sum;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: if (!fifo_empty) state_nx = BK_DIV;
			BK_DIV:  if (cnt_q == '0) state_nx = BK_SQI;
			BK_SQI:  state_nx = BK_SQQ;
			BK_SQQ:  state_nx = BK_ROOT;
			BK_ROOT: if (cnt_q == '0) state_nx = BK_MUL;
			BK_MUL:  state_nx = BK_ADD;
			BK_ADD:  state_nx = job_q.last ? BK_RT : BK_EMIT;
			BK_RT:   if (cnt_q == '0) state_nx = BK_EMIT;
			BK_EMIT: if (out_load) state_nx = BK_IDLE;
			default: state_nx = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop      = (state_q == BK_IDLE) && !fifo_empty;
		mem_we   = state_q == BK_ADD;
		out_load = (state_q == BK_EMIT) && (!out_valid_q || !out_stall);
	end

	// restoring divide steps for both means
	assign rs_i = {r_i_q[SPG_W-1:0], a_i_q[ACC_W-1]};
	assign rs_q = {r_q_q[SPG_W-1:0], a_q_q[ACC_W-1]};
	assign ge_i = rs_i >= {1'b0, job_q.spg};
	assign ge_q = rs_q >= {1'b0, job_q.spg};
	assign mi_w = neg_i_q ? -$signed(a_i_q[15:0]) : $signed(a_i_q[15:0]);
	assign mq_w = neg_q_q ? -$signed(a_q_q[15:0]) : $signed(a_q_q[15:0]);

	// square root digit step
	assign rrem_sh = {rrem_q[17:0], rx_q[31:30]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign ge_r    = rrem_sh >= trial;

	// frame divide step
	assign rt_sh = {rtr_q[PCNT_W-1:0], rtd_q[SUM_W-1]};
	assign ge_t  = rt_sh >= {1'b0, flen};

	// lag-one accumulate; first accumulating pulse of a frame starts from zero
	always_comb begin
		if (!job_q.accum)
			new_sum = rd_q[MEM_W-1:16];
		else if (job_q.fresh)
			new_sum = SUM_W'(prod_q);
		else
			new_sum = rd_q[MEM_W-1:16] + SUM_W'(prod_q);
	end

	// magnitude and correlation memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[job_q.idx] <= {new_sum, root_q};
		if (pop)
			rd_q <= mem[job_in.idx];
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				job_q   <= job_in;
				neg_i_q <= job_in.sum_i[ACC_W-1];
				neg_q_q <= job_in.sum_q[ACC_W-1];
				a_i_q   <= job_in.sum_i[ACC_W-1] ? ACC_W'(-job_in.sum_i) : ACC_W'(job_in.sum_i);
				a_q_q   <= job_in.sum_q[ACC_W-1] ? ACC_W'(-job_in.sum_q) : ACC_W'(job_in.sum_q);
				r_i_q   <= '0;
				r_q_q   <= '0;
				cnt_q   <= CNT_W'(ACC_W - 1);
			end
			BK_DIV: begin
				r_i_q <= ge_i ? rs_i - {1'b0, job_q.spg} : rs_i;
				r_q_q <= ge_q ? rs_q - {1'b0, job_q.spg} : rs_q;
				a_i_q <= {a_i_q[ACC_W-2:0], ge_i};
				a_q_q <= {a_q_q[ACC_W-2:0], ge_q};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			BK_SQI: begin
				mi_q <= mi_w;
				mq_q <= mq_w;
				pw_q <= 32'(mi_w * mi_w);
			end
			BK_SQQ: begin
				rx_q   <= pw_q + 32'(mq_q * mq_q);
				rrem_q <= '0;
				root_q <= '0;
				cnt_q  <= CNT_W'(15);
			end
			BK_ROOT: begin
				rrem_q <= ge_r ? rrem_sh - trial : rrem_sh;
				root_q <= {root_q[14:0], ge_r};
				rx_q   <= {rx_q[29:0], 2'b00};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			BK_MUL: prod_q <= rd_q[15:0] * root_q;
			BK_ADD: begin
				rtd_q <= new_sum;
				rtr_q <= '0;
				cnt_q <= CNT_W'(SUM_W - 1);
			end
			BK_RT: begin
				rtr_q <= ge_t ? rt_sh - {1'b0, flen} : rt_sh;
				rtd_q <= {rtd_q[SUM_W-2:0], ge_t};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			BK_EMIT: ;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.channel      <= job_q.channel;
			out_q.gate_index   <= 10'(job_q.gate);
			out_q.pulse_number <= job_q.pulse;
			out_q.mean_i       <= mi_q;
			out_q.mean_q       <= mq_q;
			out_q.rt_value     <= job_q.last ? rtd_q[31:0] : 32'd0;
			out_q.rt_valid     <= job_q.last;
		end
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

### sv/radar_gate_average_autocorrelation.sv
// Throughput: one sample beat per cycle while the 4-entry job queue has room; the back end
//   takes one gate at a time through its bit-serial divides and root, and a stalled result holds it.
// Reset (arst_n low): position counters, queue and result valid cleared, pulse_count = 800.
//   The magnitude/sum memory is not cleared; no clearing pass.
// Depends on rgaa_pkg, rgaa_front, rgaa_job_fifo, rgaa_back.
`default_nettype none
module radar_gate_average_autocorrelation import rgaa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire in_item_t          in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_item_t              out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [PCNT_W-1:0] cfg_data
);

	logic [PCNT_W-1:0] pulse_count_q, flen;
	logic              push, pop, full, empty;
	job_t              wr_job, rd_job;

	assign cfg_ready = 1'b1;

	// pulse_count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pulse_count_q <= PC_RESET;
		else if (cfg_valid && cfg_ready)
			pulse_count_q <= cfg_data;
	end

	// frame length clamped to 2..4096
	always_comb begin
		priority if (pulse_count_q < 13'd2)
			flen = 13'd2;
		else if (pulse_count_q > 13'd4096)
			flen = 13'd4096;
		else
			flen = pulse_count_q;
	end

	rgaa_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .flen,
		.fifo_full(full), .push, .job(wr_job)
	);

	rgaa_job_fifo u_fifo (
		.clk, .arst_n, .push, .wr_job, .pop, .rd_job, .full, .empty
	);

	rgaa_back u_back (
		.clk, .arst_n, .fifo_empty(empty), .job_in(rd_job), .pop, .flen,
		.out_valid, .out_stall, .out_data
	);

endmodule
`default_nettype wire

### sv/rgaa_checker.sv
// Port-level checks for the radar gate averaging top level, bound in below.
// Depends on rgaa_pkg.
`default_nettype none
module rgaa_checker import rgaa_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire in_item_t          in_data,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire out_item_t         out_data,
	input wire logic              cfg_valid,
	input wire logic              cfg_ready,
	input wire logic [PCNT_W-1:0] cfg_data
);

	// a stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed under stall");

	// rt_value is zero unless final
	a_rt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.rt_valid |-> out_data.rt_value == 32'd0)
		else $error("rt_value nonzero on non-final beat");

	// gate index in range
	a_gate_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.gate_index < 10'(GATES))
		else $error("gate_index out of range");

	// a stalled sample beat stays
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("sample beat dropped or changed under stall");

	// written configuration data is known
	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !$isunknown(cfg_data))
		else $error("unknown pulse_count written");

endmodule

bind radar_gate_average_autocorrelation rgaa_checker u_rgaa_checker (.*);
`default_nettype wire

### verif/tb.sv
// Self-checking bench for radar_gate_average_autocorrelation: bursty IQ pulse traffic,
// a gate-level predictor with its own magnitude and correlation memories, stalled output.
// Depends on rgaa_pkg and the RTL top level only.
`default_nettype none
module tb;
	import rgaa_pkg::*;

	localparam int WATCHDOG_LIMIT = 10000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int HOLD_AT_GATE   = 300;
	localparam int SETTLE_CYCLES  = 200;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_item_t          in_data;
	logic              out_valid;
	logic              out_stall;
	out_item_t         out_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [PCNT_W-1:0] cfg_data;

	radar_gate_average_autocorrelation i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Pending sample beats and expected gate results
	in_item_t  sample_fifo[$];
	out_item_t gate_expect[$];
	int        mismatches;
	int        gates_seen;
	bit        sample_taken;

	// Predictor state
	logic [PCNT_W-1:0]  frame_cfg;
	logic [15:0]        last_mag [0:2*GATES-1];
	logic [SUM_W-1:0]   lag_sum  [0:2*GATES-1];
	longint             acc_i, acc_q;
	int unsigned        gate_fill, gate_len, chan_pos, chan_len, gate_num;
	logic               chan;
	logic [PULSE_W-1:0] pulse_num;
	bit                 pulse_open;

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Advance the gate model by one accepted sample beat
	task automatic predict_sample(in_item_t it);
		int unsigned     flen, idx;
		bit              last;
		longint          mi, mq;
		longint unsigned mag;
		logic [63:0]     prod;
		out_item_t       r;
		flen = (frame_cfg < 2) ? 2 : (frame_cfg > 4096) ? 4096 : frame_cfg;
		last = (pulse_num + 1) >= flen;
		if (!pulse_open) begin
			// empty pulse start is dropped
			if (it.valid_samples == 0)
				return;
			chan_len   = it.valid_samples;
			gate_len   = it.valid_samples / GATES;
			chan_pos   = 0;
			gate_fill  = 0;
			gate_num   = 0;
			chan       = 0;
			acc_i      = 0;
			acc_q      = 0;
			pulse_open = 1;
		end
		if (gate_len > 0 && gate_num < GATES) begin
			acc_i += longint'(it.sample_i);
			acc_q += longint'(it.sample_q);
			gate_fill++;
			if (gate_fill >= gate_len) begin
				mi  = acc_i / longint'(gate_len);
				mq  = acc_q / longint'(gate_len);
				mag = floor_sqrt(longint'(mi * mi + mq * mq));
				idx = chan * GATES + gate_num;
				if (pulse_num >= 1) begin
					prod         = 64'(last_mag[idx]) * 64'(mag);
					lag_sum[idx] = SUM_W'(64'(lag_sum[idx]) + prod);
				end
				last_mag[idx] = mag[15:0];
				r.channel      = chan;
				r.gate_index   = 10'(gate_num);
				r.pulse_number = pulse_num;
				r.mean_i       = mi[15:0];
				r.mean_q       = mq[15:0];
				r.rt_value     = 0;
				r.rt_valid     = 0;
				if (last) begin
					r.rt_value   = 32'(64'(lag_sum[idx]) / 64'(flen));
					r.rt_valid   = 1;
					lag_sum[idx] = 0;
				end
				gate_expect.push_back(r);
				acc_i     = 0;
				acc_q     = 0;
				gate_fill = 0;
				gate_num++;
			end
		end
		chan_pos++;
		if (chan_pos >= chan_len) begin
			chan_pos  = 0;
			gate_fill = 0;
			gate_num  = 0;
			acc_i     = 0;
			acc_q     = 0;
			if (chan == 0) begin
				chan = 1;
			end else begin
				chan       = 0;
				pulse_open = 0;
				if (last) begin
					pulse_num = 0;
					for (int k = 0; k < 2 * GATES; k++)
						lag_sum[k] = 0;
				end else begin
					pulse_num = pulse_num + 1;
				end
			end
		end
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// One pulse: vertical then horizontal channel, vs samples each
	task automatic queue_pulse(int unsigned vs, bit extremes);
		in_item_t it;
		for (int k = 0; k < 2 * vs; k++) begin
			it.sample_i      = pick_sample();
			it.sample_q      = pick_sample();
			it.valid_samples = (k == 0) ? 16'(vs) : 16'($urandom);
			if (extremes && k < 4) begin
				it.sample_i = (k[0]) ? 16'h7FFF : 16'h8000;
				it.sample_q = (k[1]) ? 16'h7FFF : 16'h8000;
			end
			sample_fifo.push_back(it);
		end
	endtask

	task automatic queue_empty_starts(int n);
		in_item_t it;
		for (int k = 0; k < n; k++) begin
			it.sample_i      = 16'($urandom);
			it.sample_q      = 16'($urandom);
			it.valid_samples = 0;
			sample_fifo.push_back(it);
		end
	endtask

	task automatic wait_drained();
		while (sample_fifo.size() != 0 || in_valid || gate_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pulse_count(logic [PCNT_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// Clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Sequencer: directed opening, short pulses at several frame lengths, final gated pulse
	initial begin
		logic [PCNT_W-1:0] frame_set [4];
		frame_set = '{13'd3, 13'd8191, 13'd0, 13'd4096};
		in_valid   = 0;
		in_data    = '0;
		out_stall  = 0;
		cfg_valid  = 0;
		cfg_data   = '0;
		mismatches = 0;
		gates_seen = 0;
		frame_cfg  = PC_RESET;
		for (int k = 0; k < 2 * GATES; k++) begin
			last_mag[k] = 0;
			lag_sum[k]  = 0;
		end
		acc_i      = 0;
		acc_q      = 0;
		gate_fill  = 0;
		gate_len   = 0;
		chan_pos   = 0;
		chan_len   = 0;
		gate_num   = 0;
		chan       = 0;
		pulse_num  = 0;
		pulse_open = 0;
		arst_n     = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: empty starts, full first pulse at reset frame length, short pulses
		queue_empty_starts(3);
		queue_pulse(GATES, 1);
		queue_pulse(1, 0);
		queue_empty_starts(2);
		queue_pulse($urandom_range(2, 20), 0);
		wait_drained();

		// Short pulses under clamped and plain frame lengths
		foreach (frame_set[p]) begin
			write_pulse_count(frame_set[p]);
			frame_cfg = frame_set[p];
			repeat ($urandom_range(1, 2)) begin
				if ($urandom_range(0, 3) == 0)
					queue_empty_starts($urandom_range(1, 3));
				queue_pulse($urandom_range(1, 8), 0);
			end
			wait_drained();
		end

		// Frame length below the floor: next gated pulse closes the frame
		write_pulse_count(13'd1);
		frame_cfg = 13'd1;
		queue_pulse($urandom_range(GATES, GATES + 20), 0);
		wait_drained();

		if (mismatches == 0)
			$display("radar_gate_average_autocorrelation verification clean");
		else
			$display("radar_gate_average_autocorrelation verification failed");
		$finish;
	end

	// Driver: bursts of sample beats separated by random gaps
	int burst_left, gap_left;
	initial begin
		burst_left = 1;
		gap_left   = 0;
	end
	always @(negedge clk) begin
		if (arst_n && (!in_valid || sample_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 0;
				gap_left--;
			end else if (sample_fifo.size() != 0) begin
				in_data  <= sample_fifo.pop_front();
				in_valid <= 1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 200);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Receiver stall pattern, with one long hold-off after HOLD_AT_GATE gate results are taken
	int  stall_pct, stall_age, hold_left;
	bit  hold_done;
	initial begin
		stall_pct = 0;
		stall_age = 0;
		hold_left = 0;
		hold_done = 0;
	end
	always @(negedge clk) begin
		stall_age++;
		if (stall_age >= 700) begin
			stall_age = 0;
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 30;
				default: stall_pct = 75;
			endcase
		end
		if (!hold_done && gates_seen >= HOLD_AT_GATE) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Monitor: predict on accepted samples, check accepted gate results, watchdog
	int idle_cycles;
	initial idle_cycles = 0;
	always @(posedge clk) begin
		out_item_t e;
		sample_taken = arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (sample_taken)
				predict_sample(in_data);
			if (out_valid && !out_stall) begin
				gates_seen++;
				if (gate_expect.size() == 0) begin
					$error("unexpected gate result ch=%0d gate=%0d",
						out_data.channel, out_data.gate_index);
					mismatches++;
				end else begin
					e = gate_expect.pop_front();
					if (out_data.channel !== e.channel) begin
						$error("channel exp %0d got %0d", e.channel, out_data.channel);
						mismatches++;
					end
					if (out_data.gate_index !== e.gate_index) begin
						$error("gate_index exp %0d got %0d", e.gate_index, out_data.gate_index);
						mismatches++;
					end
					if (out_data.pulse_number !== e.pulse_number) begin
						$error("pulse_number exp %0d got %0d",
							e.pulse_number, out_data.pulse_number);
						mismatches++;
					end
					if (out_data.mean_i !== e.mean_i) begin
						$error("mean_i exp %0d got %0d", e.mean_i, out_data.mean_i);
						mismatches++;
					end
					if (out_data.mean_q !== e.mean_q) begin
						$error("mean_q exp %0d got %0d", e.mean_q, out_data.mean_q);
						mismatches++;
					end
					if (out_data.rt_value !== e.rt_value) begin
						$error("rt_value exp %0d got %0d", e.rt_value, out_data.rt_value);
						mismatches++;
					end
					if (out_data.rt_valid !== e.rt_valid) begin
						$error("rt_valid exp %0d got %0d", e.rt_valid, out_data.rt_valid);
						mismatches++;
					end
				end
			end
			if (sample_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("radar_gate_average_autocorrelation verification failed");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire

### sim.f
sv/rgaa_pkg.sv
sv/rgaa_front.sv
sv/rgaa_job_fifo.sv
sv/rgaa_back.sv
sv/radar_gate_average_autocorrelation.sv
sv/rgaa_checker.sv
verif/tb.sv
